// ===== src/hbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbe_pkg
// Shared widths, operation codes and defaults for the byte encoder.
// ----------------------------------------------------------------------------
package hbe_pkg;

    localparam int OP_W             = 2;
    localparam int SYM_W            = 8;
    localparam int WORD_W           = 32;
    localparam int LEN_W            = 6;
    localparam int BYTE_W           = 8;
    localparam int COUNT_W          = 64;
    localparam int TABLE_DEPTH      = 256;
    localparam int COUNT_BYTES      = COUNT_W / BYTE_W;
    localparam int DEF_MAX_CODE_LEN = 32;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } t_op;

endpackage

// ===== src/huffman_byte_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_byte_encoder
// Prefix-code bit packer: loads a 256-entry code table, appends code bits MSB
// first and emits full bytes; a flush sends the padded tail and the bit count.
// ----------------------------------------------------------------------------
// An encode beat reads the table memory at the edge that accepts it; merge
// and emit follow, loading the output register, from which its first byte
// is taken. Throughput: one item per cycle while each item yields at most
// one byte and the output is not stalled; the single output byte per cycle
// sets the rate, so an encode that leaves more than one full byte pending
// holds input until drained, and a flush until its pad and count bytes go.
// Reset clears the table valid bits, accumulator, counters and output valid.
// ----------------------------------------------------------------------------
module huffman_byte_encoder #(
    parameter int MAX_CODE_LEN = hbe_pkg::DEF_MAX_CODE_LEN
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [hbe_pkg::OP_W-1:0]     i_op,
    input  logic [hbe_pkg::SYM_W-1:0]    i_symbol,
    input  logic [hbe_pkg::WORD_W-1:0]   i_code_word,
    input  logic [hbe_pkg::LEN_W-1:0]    i_code_length,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [hbe_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                         o_last
);

    localparam int XW  = MAX_CODE_LEN + hbe_pkg::WORD_W;
    localparam int LW  = hbe_pkg::LEN_W;

    logic                    accept;
    logic                    is_load, is_encode, is_flush;
    logic [LW-1:0]           clamp_len;
    logic [XW-1:0]           wide_word, masked_word, aligned_word;
    logic [MAX_CODE_LEN-1:0] rd_code;
    logic [LW-1:0]           rd_len;
    logic                    take;
    logic                    r_s1_valid, n_s1_valid;
    logic                    r_s1_flush;

    assign accept    = i_in_valid && !o_in_stall;
    assign is_load   = (i_op == hbe_pkg::OP_LOAD);
    assign is_encode = (i_op == hbe_pkg::OP_ENCODE);
    assign is_flush  = (i_op == hbe_pkg::OP_FLUSH);

    // Loads are stored masked and left-aligned to the longest code, so the
    // packer only needs a shift by the few pending bits.
    assign clamp_len    = (i_code_length > LW'(MAX_CODE_LEN)) ? LW'(MAX_CODE_LEN)
                                                              : i_code_length;
    assign wide_word    = XW'(i_code_word);
    assign masked_word  = wide_word & ~({XW{1'b1}} << clamp_len);
    assign aligned_word = masked_word << (LW'(MAX_CODE_LEN) - clamp_len);

    hbe_table #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (accept && is_load),
        .i_rd_en   (accept && is_encode),
        .i_addr    (i_symbol),
        .i_wr_code (aligned_word[MAX_CODE_LEN-1:0]),
        .i_wr_len  (clamp_len),
        .o_rd_code (rd_code),
        .o_rd_len  (rd_len)
    );

    hbe_packer #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_packer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (r_s1_valid),
        .i_item_flush (r_s1_flush),
        .i_item_code  (rd_code),
        .i_item_len   (rd_len),
        .o_take       (take),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_last       (o_last)
    );

    assign o_in_stall = r_s1_valid && !take;

    // Only encode and flush beats travel on to the packer.
    always_comb begin
        n_s1_valid = r_s1_valid && !take;
        if (accept && (is_encode || is_flush)) begin
            n_s1_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_flush <= is_flush;
        end
    end

endmodule

// ===== src/hbe_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbe_table
// Code table: a 256-entry synchronous memory holding the left-aligned code
// and its length, with a valid bit per entry so unloaded symbols read empty.
// ----------------------------------------------------------------------------
module hbe_table #(
    parameter int MAX_CODE_LEN = hbe_pkg::DEF_MAX_CODE_LEN
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic                     i_rd_en,
    input  logic [hbe_pkg::SYM_W-1:0] i_addr,
    input  logic [MAX_CODE_LEN-1:0] i_wr_code,
    input  logic [hbe_pkg::LEN_W-1:0] i_wr_len,
    output logic [MAX_CODE_LEN-1:0] o_rd_code,
    output logic [hbe_pkg::LEN_W-1:0] o_rd_len
);

    localparam int EW = MAX_CODE_LEN + hbe_pkg::LEN_W;

    logic [EW-1:0] r_mem [hbe_pkg::TABLE_DEPTH];
    logic [hbe_pkg::TABLE_DEPTH-1:0] r_vld;
    logic [EW-1:0] r_rd_data;
    logic          r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= {i_wr_code, i_wr_len};
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= r_vld[i_addr];
            end
        end
    end

    // An entry that was never loaded behaves as an empty code.
    assign o_rd_code = r_rd_hit ? r_rd_data[EW-1 -: MAX_CODE_LEN] : '0;
    assign o_rd_len  = r_rd_hit ? r_rd_data[hbe_pkg::LEN_W-1:0] : '0;

endmodule

// ===== src/hbe_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbe_packer
// Bit accumulator and output register: merges codes MSB first, emits one byte
// per cycle unless stalled, and sends the pad byte and bit count on a flush.
// ----------------------------------------------------------------------------
module hbe_packer #(
    parameter int MAX_CODE_LEN = hbe_pkg::DEF_MAX_CODE_LEN
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_item_valid,
    input  logic                        i_item_flush,
    input  logic [MAX_CODE_LEN-1:0]     i_item_code,
    input  logic [hbe_pkg::LEN_W-1:0]   i_item_len,
    output logic                        o_take,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [hbe_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                        o_last
);

    localparam int BW  = hbe_pkg::BYTE_W;
    localparam int AW  = MAX_CODE_LEN + BW - 1;
    localparam int PCW = $clog2(AW + 1);
    localparam int FIW = $clog2(hbe_pkg::COUNT_BYTES + 1);

    // The accumulator is left-aligned: the oldest pending bit is bit AW-1 and
    // everything below the pending bits is zero.
    logic [AW-1:0]                 r_acc, n_acc;
    logic [PCW-1:0]                r_pc, n_pc;
    logic [hbe_pkg::COUNT_W-1:0]   r_total, n_total;
    logic                          r_fl, n_fl;
    logic [FIW-1:0]                r_fidx, n_fidx;
    logic                          r_ov, n_ov;
    logic [BW-1:0]                 r_byte, n_byte;
    logic                          r_last, n_last;

    logic                          out_free;
    logic [AW-1:0]                 merged_acc, eff_acc;
    logic [PCW-1:0]                merged_pc, eff_pc, rem_pc;

    assign o_take   = i_item_valid && !r_fl && (r_pc < PCW'(BW));
    assign out_free = !r_ov || !i_out_stall;

    assign merged_acc = r_acc | ({i_item_code, {(BW-1){1'b0}}} >> r_pc[2:0]);
    assign merged_pc  = r_pc + PCW'(i_item_len);
    assign eff_acc    = (o_take && !i_item_flush) ? merged_acc : r_acc;
    assign eff_pc     = (o_take && !i_item_flush) ? merged_pc : r_pc;
    assign rem_pc     = eff_pc - PCW'(BW);

    always_comb begin
        n_acc   = eff_acc;
        n_pc    = eff_pc;
        n_total = r_total;
        n_fl    = r_fl;
        n_fidx  = r_fidx;
        n_ov    = r_ov && i_out_stall;
        n_byte  = r_byte;
        n_last  = r_last;

        if (o_take && !i_item_flush) begin
            n_total = r_total + hbe_pkg::COUNT_W'(i_item_len);
        end

        if (r_fl) begin
            if (out_free) begin
                n_ov = 1'b1;
                if (r_fidx == '0) begin
                    // Partial byte, zero padded, then the accumulator and pending count restart.
                    n_byte = r_acc[AW-1 -: BW];
                    n_last = 1'b0;
                    n_acc  = '0;
                    n_pc   = '0;
                end else begin
                    // Bit count goes out low byte first; shifting clears it.
                    n_byte  = r_total[BW-1:0];
                    n_total = r_total >> BW;
                    n_last  = (r_fidx == FIW'(hbe_pkg::COUNT_BYTES));
                    if (r_fidx == FIW'(hbe_pkg::COUNT_BYTES)) begin
                        n_fl = 1'b0;
                    end
                end
                n_fidx = r_fidx + FIW'(1);
            end
        end else if ((eff_pc >= PCW'(BW)) && out_free) begin
            n_ov   = 1'b1;
            n_byte = eff_acc[AW-1 -: BW];
            n_last = (rem_pc < PCW'(BW));
            n_acc  = eff_acc << BW;
            n_pc   = rem_pc;
        end

        if (o_take && i_item_flush) begin
            n_fl   = 1'b1;
            n_fidx = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_pc    <= '0;
            r_total <= '0;
            r_fl    <= 1'b0;
            r_fidx  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_pc    <= n_pc;
            r_total <= n_total;
            r_fl    <= n_fl;
            r_fidx  <= n_fidx;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
    end

    assign o_out_valid = r_ov;
    assign o_out_byte  = r_byte;
    assign o_last      = r_last;

endmodule
